// File: hw/rtl/vertex_transform_4x4_core_macros.svh
// Assertion macros used by the vertex transform core.
`ifndef VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH
`define VERTEX_TRANSFORM_4X4_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clock, off during reset
`define VT44_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vt44 assertion failed");
// next-cycle implication
`define VT44_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vt44 assertion failed");
`else
`define VT44_ASSERT_NOW(label, ante, cons)
`define VT44_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hw/rtl/vt44_pkg.sv
// Package: types, constants and reset values for the 4x4 vertex transform.
`default_nettype none

package vt44_pkg;

   localparam int WORD_W            = 32;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int NUM_LANES         = 4;
   localparam int NUM_REGS          = 8;
   localparam int CSR_IDX_W         = $clog2(NUM_REGS);
   localparam int CSR_DATA_W        = 2 * WORD_W;
   localparam int PROD_W            = 2 * WORD_W;
   localparam int SUM_W             = PROD_W + 2;

   typedef enum logic [1:0] {
      CMD_FULL  = 2'd0,
      CMD_POINT = 2'd1,
      CMD_DIR   = 2'd2
   } cmd_type;

   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // identity matrix
   localparam csr_data_type CFG_RESET [NUM_REGS] = '{
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0000_0000,
      64'h0000_0000_0001_0000,
      64'h0000_0000_0000_0000,
      64'h0001_0000_0000_0000
   };

   localparam logic signed [WORD_W-1:0] SAT_MAX = {1'b0, {(WORD_W-1){1'b1}}};
   localparam logic signed [WORD_W-1:0] SAT_MIN = {1'b1, {(WORD_W-1){1'b0}}};

   typedef struct packed {
      logic [1:0]               cmd;
      logic signed [WORD_W-1:0] in_x;
      logic signed [WORD_W-1:0] in_y;
      logic signed [WORD_W-1:0] in_z;
      logic signed [WORD_W-1:0] in_w;
   } req_word_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] out_x;
      logic signed [WORD_W-1:0] out_y;
      logic signed [WORD_W-1:0] out_z;
      logic signed [WORD_W-1:0] out_w;
      logic                     clipped;
   } rsp_word_type;

endpackage

`default_nettype wire

// File: hw/rtl/vt44_lane.sv
// One output lane: four registered products, sum, shift and saturate.
`default_nettype none

module vt44_lane #(
   parameter int FRAC_BITS = vt44_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic signed [vt44_pkg::WORD_W-1:0]  op_a [vt44_pkg::NUM_LANES],
   input  logic signed [vt44_pkg::WORD_W-1:0]  op_b [vt44_pkg::NUM_LANES],
   input  logic                                keep,
   output logic signed [vt44_pkg::WORD_W-1:0]  value,
   output logic                                clip
);

   localparam int W = vt44_pkg::WORD_W;
   localparam int N = vt44_pkg::NUM_LANES;
   localparam int PW = vt44_pkg::PROD_W;
   localparam int SW = vt44_pkg::SUM_W;

   logic signed [PW-1:0] prod_in [N];
   logic signed [PW-1:0] prod_ff [N];
   logic                 keep_ff;
   logic signed [SW-1:0] sum;
   logic signed [SW-1:0] shifted;
   logic [SW-W:0]        high_bits;
   logic                 ovf;
   logic signed [W-1:0]  value_in;
   logic signed [W-1:0]  value_ff;
   logic                 clip_in;
   logic                 clip_ff;

   always_comb begin
      for (int j = 0; j < N; j++) begin
         prod_in[j] = op_a[j] * op_b[j];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      keep_ff <= keep;
   end

   always_comb begin
      sum = '0;
      for (int j = 0; j < N; j++) begin
         sum = sum + SW'(prod_ff[j]);
      end
      shifted   = sum >>> FRAC_BITS;
      high_bits = shifted[SW-1:W-1];
      ovf       = !((&high_bits) || !(|high_bits));
      if (!keep_ff) begin
         value_in = '0;
      end else if (ovf) begin
         value_in = shifted[SW-1] ? vt44_pkg::SAT_MIN : vt44_pkg::SAT_MAX;
      end else begin
         value_in = shifted[W-1:0];
      end
      clip_in = keep_ff && ovf;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      clip_ff  <= clip_in;
   end

   assign value = value_ff;
   assign clip  = clip_ff;

endmodule

`default_nettype wire

// File: hw/rtl/vertex_transform_4x4_core.sv
// Top level of the 4x4 vertex transform: matrix registers, operand select, four lanes.
// A word taken at a clock edge passes the input, product and result registers to rsp_valid and rsp_word.
// Throughput: one word per cycle while busy is low; input register, product register, result register.
// busy is high during reset and the first cycle after it; the receiver cannot stall.
// Synchronous reset loads the identity matrix and clears all valid flags.
`default_nettype none
`include "vertex_transform_4x4_core_macros.svh"

module vertex_transform_4x4_core #(
   parameter int FRAC_BITS = vt44_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  vt44_pkg::req_word_type               req_word,
   output logic                                 rsp_valid,
   output vt44_pkg::rsp_word_type               rsp_word,
   input  logic                                 csr_wr_en,
   input  logic [vt44_pkg::CSR_IDX_W-1:0]       csr_index,
   input  vt44_pkg::csr_data_type               csr_wdata
);

   localparam int W = vt44_pkg::WORD_W;
   localparam int N = vt44_pkg::NUM_LANES;
   localparam logic signed [W-1:0] FIX_ONE = W'(1) << FRAC_BITS;

   vt44_pkg::csr_data_type cfg_ff [vt44_pkg::NUM_REGS];
   logic                   busy_ff;
   logic                   req_valid_ff;
   vt44_pkg::req_word_type req_word_ff;
   logic                   prod_valid_ff;
   logic                   rsp_valid_ff;

   logic signed [W-1:0]    m [N][N];
   logic signed [W-1:0]    op_a [N][N];
   logic signed [W-1:0]    op_b [N];
   logic [N-1:0]           keep;
   logic signed [W-1:0]    lane_value [N];
   logic [N-1:0]           lane_clip;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= vt44_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         cfg_ff[csr_index] <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         req_valid_ff  <= 1'b0;
         prod_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         req_valid_ff  <= start && !busy_ff;
         prod_valid_ff <= req_valid_ff;
         rsp_valid_ff  <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy_ff) begin
         req_word_ff <= req_word;
      end
   end

   // entry (r, c): register 2r + c/2, odd columns in the upper half
   always_comb begin
      for (int r = 0; r < N; r++) begin
         for (int c = 0; c < N; c++) begin
            m[r][c] = cfg_ff[vt44_pkg::CSR_IDX_W'(2 * r + c / 2)][(c % 2) * W +: W];
         end
      end
   end

   always_comb begin
      op_b[0] = req_word_ff.in_x;
      op_b[1] = req_word_ff.in_y;
      op_b[2] = req_word_ff.in_z;
      for (int i = 0; i < N; i++) begin
         for (int j = 0; j < N; j++) begin
            op_a[i][j] = (req_word_ff.cmd == vt44_pkg::CMD_FULL) ? m[i][j] : m[j][i];
         end
      end
      unique case (req_word_ff.cmd) inside
         vt44_pkg::CMD_FULL: begin
            op_b[3] = req_word_ff.in_w;
            keep    = '1;
         end
         vt44_pkg::CMD_POINT, vt44_pkg::CMD_DIR: begin
            op_b[3] = (req_word_ff.cmd == vt44_pkg::CMD_POINT) ? FIX_ONE : '0;
            keep    = '1;
            keep[N-1] = 1'b0;
         end
         default: begin
            op_b[3] = '0;
            keep    = '0;
         end
      endcase
   end

   for (genvar i = 0; i < N; i++) begin : g_lane
      vt44_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock (clock),
         .op_a  (op_a[i]),
         .op_b  (op_b),
         .keep  (keep[i]),
         .value (lane_value[i]),
         .clip  (lane_clip[i])
      );
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_word.out_x    = lane_value[0];
   assign rsp_word.out_y    = lane_value[1];
   assign rsp_word.out_z    = lane_value[2];
   assign rsp_word.out_w    = lane_value[3];
   assign rsp_word.clipped  = |lane_clip;

   `VT44_ASSERT_NEXT(a_latency, start && !busy, ##2 rsp_valid)
   `VT44_ASSERT_NOW(a_w_zero, rsp_valid && $past(req_word_ff.cmd, 2) != vt44_pkg::CMD_FULL, rsp_word.out_w == '0)
   `VT44_ASSERT_NOW(a_unused_cmd, rsp_valid && $past(req_word_ff.cmd, 2) != vt44_pkg::CMD_FULL && $past(req_word_ff.cmd, 2) != vt44_pkg::CMD_POINT && $past(req_word_ff.cmd, 2) != vt44_pkg::CMD_DIR, rsp_word == '0)

endmodule

`default_nettype wire
